>>> sv/srng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_pkg: shared definitions of the shuffled minimal-standard generator
// Constants of the Lehmer generator, the input codes, the controller command
// bundle and the generator step function.
// ----------------------------------------------------------------------------
package srng_pkg;

  localparam int unsigned VAL_W          = 31;
  localparam int unsigned TABLE_SIZE_DEF = 32;
  localparam int unsigned WARMUP_EXTRA   = 8;

  localparam logic [14:0]      LEHMER_MUL = 15'd16807;
  localparam logic [VAL_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

  // Input item kinds carried on tuser.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef struct packed {
    logic seed_load;     // load the generator with a seed
    logic seed_from_in;  // seed comes from the input item, otherwise one
    logic gen_step;      // advance the generator once
    logic table_fill;    // write the next generator word at the fill address
    logic last_load;     // previous output takes the next generator word
    logic idx_calc;      // register the table index from the previous output
    logic table_read;    // read the table at the registered index
    logic table_swap;    // take the table word, store the generator word
    logic out_load;      // load the result register
  } srng_cmd_t;

  // One generator step: (x * 16807) mod (2^31 - 1). The high part of the
  // product folds back onto the low part because 2^31 is one modulo M.
  function automatic logic [VAL_W-1:0] lehmer_next(input logic [VAL_W-1:0] x);
    logic [VAL_W+14:0] prod;
    logic [VAL_W:0]    fold;
    prod = x * LEHMER_MUL;
    fold = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[VAL_W+14:VAL_W]);
    if (fold >= {1'b0, LEHMER_MOD}) begin
      fold = fold - {1'b0, LEHMER_MOD};
    end
    return fold[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/shuffled_minstd_uniform_rng.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_minstd_uniform_rng: Lehmer generator with a Bays-Durham shuffle
// A draw item is taken in the idle state and then passes the generator step with
// the index calculation, the table read and the table swap before the result
// register is loaded; the next item is taken only after that load, which waits while an untaken result is held.
// A reseed, or the first draw after reset, first runs the warm-up that fills the table.
// Reset sets the generator to 1 and unseeded; the table is not cleared.
// ----------------------------------------------------------------------------
module shuffled_minstd_uniform_rng
  import srng_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid_i,
  output logic         s_tready_o,
  input  wire  [31:0]  s_tdata_i,   // [30:0] seed_value, [31] zero
  input  wire  [0:0]   s_tuser_i,   // [0] opcode
  output logic         m_tvalid_o,
  input  wire          m_tready_i,
  output logic [63:0]  m_tdata_o    // [30:0] random_value, [61:31] generator_word
);

  srng_cmd_t                cmd;
  logic [$clog2(TABLE_SIZE)-1:0] fill_addr;
  logic [VAL_W-1:0]         random_value;
  logic [VAL_W-1:0]         generator_word;

  srng_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tuser_i   (s_tuser_i[0]),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .cmd_o       (cmd),
    .fill_addr_o (fill_addr)
  );

  srng_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .fill_addr_i      (fill_addr),
    .seed_i           (s_tdata_i[VAL_W-1:0]),
    .random_value_o   (random_value),
    .generator_word_o (generator_word)
  );

  assign m_tdata_o = {2'b00, generator_word, random_value};

endmodule
`default_nettype wire

>>> sv/srng_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srng_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/srng_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_ctrl: sequencer of the shuffled generator
// Runs the seeding warm-up and the draw sequence, owns the handshakes.
// ----------------------------------------------------------------------------
module srng_ctrl
  import srng_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_tvalid_i,
  output logic                           s_tready_o,
  input  wire                            s_tuser_i,
  output logic                           m_tvalid_o,
  input  wire                            m_tready_i,
  output srng_cmd_t                      cmd_o,
  output logic [$clog2(TABLE_SIZE)-1:0]  fill_addr_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + WARMUP_EXTRA);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WARM = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_SWAP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seeded_q, seeded_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          if (s_tuser_i == OP_RESEED || !seeded_q) begin
            cmd_o.seed_load    = 1'b1;
            cmd_o.seed_from_in = (s_tuser_i == OP_RESEED);
            cnt_d              = CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1);
            state_d            = S_WARM;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_WARM: begin
        // The last TABLE_SIZE warm-up words fill the table from the top down.
        cmd_o.gen_step   = 1'b1;
        cmd_o.table_fill = (cnt_q < CNT_W'(TABLE_SIZE));
        if (cnt_q == '0) begin
          cmd_o.last_load = 1'b1;
          seeded_d        = 1'b1;
          state_d         = S_STEP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_STEP: begin
        cmd_o.gen_step = 1'b1;
        cmd_o.idx_calc = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        cmd_o.table_read = 1'b1;
        state_d          = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.table_swap = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o  = (state_q == S_IDLE);
  assign m_tvalid_o  = out_valid_q;
  assign fill_addr_o = cnt_q[IDX_W-1:0];

  // A draw never starts on an unfilled table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP |-> seeded_q)
    else $error("draw started before the table was seeded");

  // A reseed item always goes through the warm-up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && s_tuser_i == OP_RESEED |=> state_q == S_WARM)
    else $error("reseed item did not start the warm-up");

  // The warm-up counter stays within the warm-up length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WARM |-> cnt_q <= CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1))
    else $error("warm-up counter out of range");

  // The result register is loaded only when it is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || m_tready_i)
    else $error("result overwritten before it was taken");

  // A finished item becomes visible at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> m_tvalid_o && state_q == S_IDLE)
    else $error("result not presented after load");

endmodule
`default_nettype wire

>>> sv/srng_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srng_dp: datapath of the shuffled generator
// Generator register, previous output, index unit, shuffle table, result.
// ----------------------------------------------------------------------------
module srng_dp
  import srng_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  srng_cmd_t                      cmd_i,
  input  wire [$clog2(TABLE_SIZE)-1:0]   fill_addr_i,
  input  wire [VAL_W-1:0]                seed_i,
  output logic [VAL_W-1:0]               random_value_o,
  output logic [VAL_W-1:0]               generator_word_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
  // Index divisor 1 + (M-1)/TABLE_SIZE, done as a multiply by a rounded-up
  // reciprocal with enough fraction bits to be exact for every 31-bit value.
  localparam logic [63:0] DIV_C   = 64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_SIZE);
  localparam int unsigned SHIFT_C = VAL_W + $clog2(DIV_C);
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT_C) + DIV_C - 64'd1) / DIV_C;
  localparam int unsigned RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_FULL);

  logic [VAL_W-1:0]         lehmer_q, lehmer_d;
  logic [VAL_W-1:0]         last_q, last_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [VAL_W-1:0]         rand_q, gen_q;
  logic [VAL_W-1:0]         gen_next;
  logic [VAL_W-1:0]         seed_fix;
  logic [VAL_W+RECIP_W-1:0] idx_prod;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [VAL_W-1:0]         ram_wdata;
  logic [VAL_W-1:0]         ram_rdata;

  assign gen_next = lehmer_next(lehmer_q);

  // Seeds of zero and of the modulus itself would lock the generator at zero.
  always_comb begin
    seed_fix = VAL_W'(1);
    if (cmd_i.seed_from_in && seed_i != '0 && seed_i != LEHMER_MOD) begin
      seed_fix = seed_i;
    end
  end

  assign idx_prod = last_q * RECIP_C;

  always_comb begin
    lehmer_d = lehmer_q;
    last_d   = last_q;
    idx_d    = idx_q;
    if (cmd_i.seed_load) begin
      lehmer_d = seed_fix;
    end else if (cmd_i.gen_step) begin
      lehmer_d = gen_next;
    end
    if (cmd_i.last_load) begin
      last_d = gen_next;
    end else if (cmd_i.table_swap) begin
      last_d = ram_rdata;
    end
    if (cmd_i.idx_calc) begin
      idx_d = idx_prod[SHIFT_C +: IDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lehmer_q <= VAL_W'(1);
      last_q   <= '0;
      idx_q    <= '0;
    end else begin
      lehmer_q <= lehmer_d;
      last_q   <= last_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rand_q <= last_q;
      gen_q  <= lehmer_q;
    end
  end

  assign ram_we    = cmd_i.table_fill | cmd_i.table_swap;
  assign ram_waddr = cmd_i.table_fill ? fill_addr_i : idx_q;
  assign ram_wdata = cmd_i.table_fill ? gen_next : lehmer_q;

  srng_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.table_read),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign random_value_o   = rand_q;
  assign generator_word_o = gen_q;

endmodule
`default_nettype wire

>>> verif/shuffled_minstd_uniform_rng_checker.sv
// ----------------------------------------------------------------------------
// shuffled_minstd_uniform_rng_checker: result checker of the shuffled generator
// Watches both stream channels, keeps its own copy of the generator and the
// shuffle table, queues the expected draw for every accepted item and compares
// each accepted result with the oldest queued draw.
// ----------------------------------------------------------------------------
module shuffled_minstd_uniform_rng_checker
  import srng_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid_i,
  input  wire          s_tready_i,
  input  wire  [31:0]  s_tdata_i,   // [30:0] seed_value, [31] zero
  input  wire  [0:0]   s_tuser_i,   // [0] opcode
  input  wire          m_tvalid_i,
  input  wire          m_tready_i,
  input  wire  [63:0]  m_tdata_i,   // [30:0] random_value, [61:31] generator_word
  output int           fail_count_o,
  output int           pending_o
);

  // Divisor that maps a previous output onto a table slot.
  localparam longint unsigned SHUFFLE_DIV =
    64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_SIZE);

  typedef struct packed {
    logic [VAL_W-1:0] random_value;
    logic [VAL_W-1:0] generator_word;
  } draw_result_t;

  draw_result_t     expected_draws[$];
  logic [VAL_W-1:0] gen_word;
  logic [VAL_W-1:0] prev_out;
  logic [VAL_W-1:0] shuffle_tbl [TABLE_SIZE];
  bit               seeded;
  int               errors = 0;
  int               draws_checked = 0;
  int               outstanding = 0;

  assign fail_count_o = errors;
  assign pending_o    = outstanding;

  function automatic logic [VAL_W-1:0] minstd_step(input logic [VAL_W-1:0] x);
    longint unsigned prod;
    prod = 64'(x) * 64'(LEHMER_MUL);
    return VAL_W'(prod % 64'(LEHMER_MOD));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: draw %0d: %s", draws_checked, msg);
    errors++;
  endtask

  // Warm up from the seed; the last TABLE_SIZE words fill the table from the
  // top slot down.
  task automatic reseed_shuffle(input logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] s;
    int               j;
    s = seed;
    if (s == '0 || s == LEHMER_MOD) begin
      s = VAL_W'(1);
    end
    for (j = TABLE_SIZE + WARMUP_EXTRA - 1; j >= 0; j--) begin
      s = minstd_step(s);
      if (j < TABLE_SIZE) begin
        shuffle_tbl[j] = s;
      end
    end
    gen_word = s;
    prev_out = shuffle_tbl[0];
    seeded   = 1'b1;
  endtask

  task automatic predict_draw(input logic op, input logic [VAL_W-1:0] seed);
    longint unsigned slot;
    draw_result_t    draw;
    if (op == OP_RESEED) begin
      reseed_shuffle(seed);
    end else if (!seeded) begin
      reseed_shuffle(VAL_W'(1));
    end
    gen_word = minstd_step(gen_word);
    slot = 64'(prev_out) / SHUFFLE_DIV;
    if (slot >= TABLE_SIZE) begin
      slot = 0;
    end
    prev_out          = shuffle_tbl[slot];
    shuffle_tbl[slot] = gen_word;
    draw.random_value   = prev_out;
    draw.generator_word = gen_word;
    expected_draws.push_back(draw);
    outstanding++;
  endtask

  task automatic check_draw(input logic [63:0] word);
    draw_result_t want;
    logic [VAL_W-1:0] got_value;
    logic [VAL_W-1:0] got_word;
    got_value = word[VAL_W-1:0];
    got_word  = word[2*VAL_W-1:VAL_W];
    if (expected_draws.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d with no item outstanding",
                                got_value, got_word));
    end else begin
      want = expected_draws.pop_front();
      outstanding--;
      if (got_value !== want.random_value) begin
        report_mismatch($sformatf("random_value %0d, expected %0d",
                                  got_value, want.random_value));
      end
      if (got_word !== want.generator_word) begin
        report_mismatch($sformatf("generator_word %0d, expected %0d",
                                  got_word, want.generator_word));
      end
    end
    draws_checked++;
  endtask

  // Results are checked before the item of the same edge is predicted, so a
  // result never meets an expectation queued in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_word    = VAL_W'(1);
      prev_out    = '0;
      seeded      = 1'b0;
      outstanding = 0;
      expected_draws.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        check_draw(m_tdata_i);
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_draw(s_tuser_i[0], s_tdata_i[VAL_W-1:0]);
      end
    end
  end

endmodule

>>> verif/shuffled_minstd_uniform_rng_tb.sv
// ----------------------------------------------------------------------------
// shuffled_minstd_uniform_rng_tb: testbench of the shuffled generator
// Sends a directed set of draws and reseeds, then about 400 random items with
// random gaps on both sides and two long receiver hold-offs; a checker beside
// the block predicts every draw and counts mismatches.
// ----------------------------------------------------------------------------
module shuffled_minstd_uniform_rng_tb;
  import srng_pkg::*;

  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int LONG_HOLD      = 400;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i  = '0;
  logic [0:0]  s_tuser_i  = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [63:0] m_tdata_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit sender_burst = 1'b0;

  shuffled_minstd_uniform_rng dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  shuffled_minstd_uniform_rng_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Handshake inputs are looked at on the falling edge, where they are stable
  // until the rising edge that completes the transfer.
  task automatic send_item(input logic op, input logic [VAL_W-1:0] seed);
    int unsigned gap;
    bit          taken;
    gap = sender_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {1'b0, seed};
    do begin
      @(negedge clk_i);
      taken = s_tready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [VAL_W-1:0] random_seed();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return LEHMER_MOD;
      2:       return LEHMER_MOD - VAL_W'(1);
      3:       return VAL_W'(1);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first draw must seed itself with one; its seed field is ignored.
    send_item(OP_DRAW, LEHMER_MOD);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, 31'h2AAA_AAAA);
    send_item(OP_RESEED, '0);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    send_item(OP_RESEED, VAL_W'(1));
    send_item(OP_DRAW, 31'h5555_5555);
    // A seed equal to the modulus behaves as a seed of one.
    send_item(OP_RESEED, LEHMER_MOD);
    send_item(OP_DRAW, '0);
    send_item(OP_RESEED, LEHMER_MOD - VAL_W'(1));
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, LEHMER_MOD);
    send_item(OP_RESEED, 31'h5555_5555);
    send_item(OP_DRAW, '0);
    send_item(OP_RESEED, 31'h2AAA_AAAA);
    send_item(OP_DRAW, '0);
    send_item(OP_RESEED, VAL_W'(42));
    send_item(OP_RESEED, VAL_W'(42));
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);

    // Mostly runs of draws between occasional reseeds.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sender_burst = ((n / 40) % 3) == 1;
      if ($urandom_range(0, 99) < 12) begin
        send_item(OP_RESEED, random_seed());
      end else begin
        send_item(OP_DRAW, VAL_W'($urandom));
      end
    end
    s_tvalid_i <= 1'b0;

    // The checker counts the last item at the edge just passed, so the count
    // is looked at only from the next falling edge on.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall;
    int          got;
    bit          taken;
    got = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      // Two long hold-offs let the block back up into its input.
      if (got == 40 || got == 250) begin
        stall = LONG_HOLD;
      end else if (((got / 30) % 3) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 17);
      end
      if (stall != 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = m_tvalid_o;
        @(posedge clk_i);
      end while (!taken);
      got++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

>>> shuffled_minstd_uniform_rng.f
sv/srng_pkg.sv
sv/srng_ram.sv
sv/srng_ctrl.sv
sv/srng_dp.sv
sv/shuffled_minstd_uniform_rng.sv
verif/shuffled_minstd_uniform_rng_checker.sv
verif/shuffled_minstd_uniform_rng_tb.sv
